// File: src/cnm_pkg.sv
`timescale 1ns / 1ps

package cnm_pkg;

   // State machine codes
   localparam logic [2:0] ST_POWER_OFF = 3'd0;
   localparam logic [2:0] ST_NET_OFF   = 3'd1;
   localparam logic [2:0] ST_STARTUP   = 3'd2;
   localparam logic [2:0] ST_CHECK     = 3'd3;
   localparam logic [2:0] ST_NET_ON    = 3'd4;
   localparam logic [2:0] ST_SILENT    = 3'd5;

   // Network management command codes
   localparam logic [1:0] NC_WU = 2'd0;
   localparam logic [1:0] NC_SA = 2'd1;
   localparam logic [1:0] NC_S  = 2'd2;
   localparam logic [1:0] NC_MM = 2'd3;

   // Net status indication codes
   localparam logic [2:0] IND_OFF     = 3'd0;
   localparam logic [2:0] IND_STARTUP = 3'd1;
   localparam logic [2:0] IND_ON      = 3'd2;
   localparam logic [2:0] IND_CHECK   = 3'd3;
   localparam logic [2:0] IND_SDN     = 3'd4;

   // Bit positions of the latched receive events
   localparam int EV_STARTUP2ON     = 0;
   localparam int EV_CHECK2ON       = 1;
   localparam int EV_SILENT2STARTUP = 2;
   localparam int EV_ON2SILENT      = 3;

   // Configuration register indexes
   localparam logic [2:0] CSR_STAY_ACTIVE = 3'd0;
   localparam logic [2:0] CSR_TX_CYCLE    = 3'd1;
   localparam logic [2:0] CSR_SLEEP_ONE   = 3'd2;
   localparam logic [2:0] CSR_SLEEP_TWO   = 3'd3;
   localparam logic [2:0] CSR_TX_ENABLE   = 3'd4;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [15:0] STAY_ACTIVE_RESET = 16'd2000;
   localparam logic [15:0] TX_CYCLE_RESET    = 16'd2000;
   localparam logic [15:0] SLEEP_ONE_RESET   = 16'd2000;
   localparam logic [15:0] SLEEP_TWO_RESET   = 16'd100;

   typedef struct packed {
      logic       mode;
      logic       ignition_on;
      logic       sleep_allowed;
      logic       local_active;
      logic       wakeup_event;
      logic       sleep_granted;
      logic       comm_fault;
      logic       supply_ok;
      logic [1:0] rx_code;
      logic [5:0] rx_counter;
   } req_item_type;

   typedef struct packed {
      logic       frame_valid;
      logic [1:0] frame_code;
      logic [7:0] frame_status;
      logic [2:0] net_status;
      logic       app_tx_enable;
      logic       sleep_request;
   } rsp_item_type;

   // Control state that does not depend on the timer width
   typedef struct packed {
      logic [2:0] fsm;
      logic       al_flag;
      logic [1:0] on_code;
      logic [5:0] master_count;
      logic       master_seen;
      logic [3:0] rx_events;
      logic       wakeup_latch;
      logic       last_ignition;
      logic [2:0] status;
      logic       app_tx_held;
   } ctl_state_type;

endpackage

// File: src/cnm_ifs.sv
`timescale 1ns / 1ps

interface cnm_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic       ignition_on;
   logic       sleep_allowed;
   logic       local_active;
   logic       wakeup_event;
   logic       sleep_granted;
   logic       comm_fault;
   logic       supply_ok;
   logic [1:0] rx_code;
   logic [5:0] rx_counter;

   modport source (
      output valid, mode, ignition_on, sleep_allowed, local_active, wakeup_event,
             sleep_granted, comm_fault, supply_ok, rx_code, rx_counter,
      input  ready
   );
   modport sink (
      input  valid, mode, ignition_on, sleep_allowed, local_active, wakeup_event,
             sleep_granted, comm_fault, supply_ok, rx_code, rx_counter,
      output ready
   );
endinterface

interface cnm_rsp_if;
   logic       valid;
   logic       ready;
   logic       frame_valid;
   logic [1:0] frame_code;
   logic [7:0] frame_status;
   logic [2:0] net_status;
   logic       app_tx_enable;
   logic       sleep_request;

   modport source (
      output valid, frame_valid, frame_code, frame_status, net_status,
             app_tx_enable, sleep_request,
      input  ready
   );
   modport sink (
      input  valid, frame_valid, frame_code, frame_status, net_status,
             app_tx_enable, sleep_request,
      output ready
   );
endinterface

// File: src/cnm_csr.sv
`timescale 1ns / 1ps

module cnm_csr #(
   parameter int TIMER_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [cnm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [cnm_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output logic [TIMER_WIDTH-1:0]              stay_active_ticks,
   output logic [TIMER_WIDTH-1:0]              tx_cycle_ticks,
   output logic [TIMER_WIDTH-1:0]              sleep_one_ticks,
   output logic [TIMER_WIDTH-1:0]              sleep_two_ticks,
   output logic                                tx_enable
);

   logic [TIMER_WIDTH-1:0] stay_active_ff;
   logic [TIMER_WIDTH-1:0] tx_cycle_ff;
   logic [TIMER_WIDTH-1:0] sleep_one_ff;
   logic [TIMER_WIDTH-1:0] sleep_two_ff;
   logic                   tx_enable_ff;
   logic [31:0]            wdata_wide;
   logic [TIMER_WIDTH-1:0] wdata_timer;

   // The data word is 16 bits; a narrower timer keeps only its low bits.
   assign wdata_wide  = {16'd0, csr_wdata};
   assign wdata_timer = wdata_wide[TIMER_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         stay_active_ff <= TIMER_WIDTH'(cnm_pkg::STAY_ACTIVE_RESET);
         tx_cycle_ff    <= TIMER_WIDTH'(cnm_pkg::TX_CYCLE_RESET);
         sleep_one_ff   <= TIMER_WIDTH'(cnm_pkg::SLEEP_ONE_RESET);
         sleep_two_ff   <= TIMER_WIDTH'(cnm_pkg::SLEEP_TWO_RESET);
         tx_enable_ff   <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            cnm_pkg::CSR_STAY_ACTIVE: stay_active_ff <= wdata_timer;
            cnm_pkg::CSR_TX_CYCLE:    tx_cycle_ff    <= wdata_timer;
            cnm_pkg::CSR_SLEEP_ONE:   sleep_one_ff   <= wdata_timer;
            cnm_pkg::CSR_SLEEP_TWO:   sleep_two_ff   <= wdata_timer;
            cnm_pkg::CSR_TX_ENABLE:   tx_enable_ff   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign stay_active_ticks = stay_active_ff;
   assign tx_cycle_ticks    = tx_cycle_ff;
   assign sleep_one_ticks   = sleep_one_ff;
   assign sleep_two_ticks   = sleep_two_ff;
   assign tx_enable         = tx_enable_ff;

endmodule

// File: src/cnm_step.sv
`timescale 1ns / 1ps

module cnm_step #(
   parameter int TIMER_WIDTH = 16,
   parameter int DELAY_WIDTH = 1,
   parameter int TX_DELAY_TICKS = 1
) (
   input  cnm_pkg::req_item_type  item,
   input  cnm_pkg::ctl_state_type state_ff,
   input  logic [TIMER_WIDTH-1:0] sa_timer_ff,
   input  logic [TIMER_WIDTH-1:0] cycle_timer_ff,
   input  logic [TIMER_WIDTH-1:0] check_timer_ff,
   input  logic [TIMER_WIDTH-1:0] silent_timer_ff,
   input  logic [DELAY_WIDTH-1:0] delay_cnt_ff,
   input  logic [TIMER_WIDTH-1:0] cfg_stay_active,
   input  logic [TIMER_WIDTH-1:0] cfg_tx_cycle,
   input  logic [TIMER_WIDTH-1:0] cfg_sleep_one,
   input  logic [TIMER_WIDTH-1:0] cfg_sleep_two,
   input  logic                   cfg_tx_enable,
   output cnm_pkg::ctl_state_type state_in,
   output logic [TIMER_WIDTH-1:0] sa_timer_in,
   output logic [TIMER_WIDTH-1:0] cycle_timer_in,
   output logic [TIMER_WIDTH-1:0] check_timer_in,
   output logic [TIMER_WIDTH-1:0] silent_timer_in,
   output logic [DELAY_WIDTH-1:0] delay_cnt_in,
   output cnm_pkg::rsp_item_type  result
);

   localparam logic [TIMER_WIDTH-1:0] TIMER_ZERO = '0;
   localparam logic [TIMER_WIDTH-1:0] TIMER_ONE  = TIMER_WIDTH'(1);
   localparam logic [DELAY_WIDTH-1:0] DELAY_LAST = DELAY_WIDTH'(TX_DELAY_TICKS);

   function automatic logic [TIMER_WIDTH-1:0] dec_sat(input logic [TIMER_WIDTH-1:0] t);
      return (t != TIMER_ZERO) ? t - TIMER_ONE : t;
   endfunction

   cnm_pkg::ctl_state_type st;
   logic [TIMER_WIDTH-1:0] sa;
   logic [TIMER_WIDTH-1:0] cy;
   logic [TIMER_WIDTH-1:0] ck;
   logic [TIMER_WIDTH-1:0] sl;
   logic [DELAY_WIDTH-1:0] dc;
   logic                   send;
   logic [1:0]             send_code;
   logic                   sleep_req;
   logic                   cmd_on;
   logic [7:0]             status_byte;

   always_comb begin
      st        = state_ff;
      sa        = sa_timer_ff;
      cy        = cycle_timer_ff;
      ck        = check_timer_ff;
      sl        = silent_timer_ff;
      dc        = delay_cnt_ff;
      send      = 1'b0;
      send_code = cnm_pkg::NC_WU;
      sleep_req = 1'b0;
      cmd_on    = ~item.sleep_allowed;
      status_byte = 8'd0;
      result    = '0;

      if (item.mode) begin
         // Received master frame: latch events for the next tick.
         st.master_count = item.rx_counter;
         if (st.fsm == cnm_pkg::ST_STARTUP && item.rx_code == cnm_pkg::NC_SA)
            st.rx_events[cnm_pkg::EV_STARTUP2ON] = 1'b1;
         if (st.fsm == cnm_pkg::ST_CHECK && item.rx_code == cnm_pkg::NC_SA)
            st.rx_events[cnm_pkg::EV_CHECK2ON] = 1'b1;
         if (st.fsm == cnm_pkg::ST_NET_OFF && st.wakeup_latch &&
             item.rx_code == cnm_pkg::NC_SA)
            st.rx_events[cnm_pkg::EV_CHECK2ON] = 1'b1;
         if (st.fsm == cnm_pkg::ST_SILENT && item.rx_code == cnm_pkg::NC_WU)
            st.rx_events[cnm_pkg::EV_SILENT2STARTUP] = 1'b1;
         if (st.fsm == cnm_pkg::ST_NET_ON) begin
            if (item.rx_code == cnm_pkg::NC_S && !st.last_ignition)
               st.rx_events[cnm_pkg::EV_ON2SILENT] = 1'b1;
            if ((item.rx_code == cnm_pkg::NC_SA && !st.last_ignition) ||
                (item.rx_code == cnm_pkg::NC_MM && st.last_ignition)) begin
               st.on_code     = item.rx_code;
               sa             = cfg_stay_active;
               st.status      = cnm_pkg::IND_ON;
               cy             = TIMER_ONE;
               st.master_seen = 1'b1;
            end
         end
      end else begin
         st.last_ignition = item.ignition_on;
         if (item.wakeup_event)
            st.wakeup_latch = 1'b1;

         unique case (st.fsm)
            cnm_pkg::ST_POWER_OFF, cnm_pkg::ST_NET_OFF: begin
               if (st.fsm == cnm_pkg::ST_POWER_OFF) begin
                  st.status = cnm_pkg::IND_OFF;
                  st.fsm    = cnm_pkg::ST_NET_OFF;
               end
               st.al_flag = item.local_active;
               if (item.ignition_on) begin
                  st.wakeup_latch = 1'b0;
                  st.on_code = cnm_pkg::NC_MM;
                  send       = 1'b1;
                  send_code  = cnm_pkg::NC_MM;
                  sa         = cfg_stay_active;
                  cy         = cfg_tx_cycle;
                  st.status  = cnm_pkg::IND_ON;
                  st.fsm     = cnm_pkg::ST_NET_ON;
                  st.rx_events[cnm_pkg::EV_CHECK2ON] = 1'b0;
               end else if (cmd_on) begin
                  st.wakeup_latch = 1'b0;
                  sa        = cfg_stay_active;
                  send      = 1'b1;
                  send_code = cnm_pkg::NC_WU;
                  st.status = cnm_pkg::IND_STARTUP;
                  st.fsm    = cnm_pkg::ST_STARTUP;
                  st.rx_events[cnm_pkg::EV_CHECK2ON] = 1'b0;
               end else if (st.wakeup_latch) begin
                  st.wakeup_latch = 1'b0;
                  ck        = cfg_sleep_one;
                  st.status = cnm_pkg::IND_CHECK;
                  st.fsm    = cnm_pkg::ST_CHECK;
               end
            end
            cnm_pkg::ST_STARTUP: begin
               if (item.ignition_on) begin
                  st.on_code = cnm_pkg::NC_MM;
                  send       = 1'b1;
                  send_code  = cnm_pkg::NC_MM;
                  sa         = cfg_stay_active;
                  cy         = cfg_tx_cycle;
                  st.status  = cnm_pkg::IND_ON;
                  st.fsm     = cnm_pkg::ST_NET_ON;
                  st.rx_events[cnm_pkg::EV_STARTUP2ON] = 1'b0;
               end else begin
                  st.al_flag = item.local_active;
                  sa = dec_sat(sa);
                  if (sa == TIMER_ZERO || st.rx_events[cnm_pkg::EV_STARTUP2ON]) begin
                     st.rx_events[cnm_pkg::EV_STARTUP2ON] = 1'b0;
                     send      = 1'b1;
                     send_code = cnm_pkg::NC_SA;
                     sa        = cfg_stay_active;
                     cy        = cfg_tx_cycle;
                     st.status = cnm_pkg::IND_ON;
                     st.fsm    = cnm_pkg::ST_NET_ON;
                  end
               end
            end
            cnm_pkg::ST_CHECK: begin
               ck = dec_sat(ck);
               if (item.ignition_on) begin
                  st.on_code = cnm_pkg::NC_MM;
                  send       = 1'b1;
                  send_code  = cnm_pkg::NC_MM;
                  sa         = cfg_stay_active;
                  cy         = cfg_tx_cycle;
                  st.status  = cnm_pkg::IND_ON;
                  st.fsm     = cnm_pkg::ST_NET_ON;
                  st.rx_events[cnm_pkg::EV_CHECK2ON] = 1'b0;
               end else if (st.rx_events[cnm_pkg::EV_CHECK2ON]) begin
                  st.rx_events[cnm_pkg::EV_CHECK2ON] = 1'b0;
                  send      = 1'b1;
                  send_code = cnm_pkg::NC_SA;
                  sa        = cfg_stay_active;
                  cy        = cfg_tx_cycle;
                  st.status = cnm_pkg::IND_ON;
                  st.fsm    = cnm_pkg::ST_NET_ON;
               end else if (cmd_on) begin
                  st.al_flag = 1'b1;
                  send       = 1'b1;
                  send_code  = cnm_pkg::NC_WU;
                  sa         = cfg_stay_active;
                  st.status  = cnm_pkg::IND_STARTUP;
                  st.fsm     = cnm_pkg::ST_STARTUP;
                  st.rx_events[cnm_pkg::EV_CHECK2ON] = 1'b0;
               end else if (ck == TIMER_ZERO) begin
                  st.wakeup_latch = 1'b0;
                  sleep_req = 1'b1;
                  if (item.sleep_granted) begin
                     st.status = cnm_pkg::IND_OFF;
                     st.fsm    = cnm_pkg::ST_NET_OFF;
                     st.rx_events[cnm_pkg::EV_CHECK2ON] = 1'b0;
                  end
               end
            end
            cnm_pkg::ST_SILENT: begin
               sl = dec_sat(sl);
               if (item.ignition_on) begin
                  st.on_code = cnm_pkg::NC_MM;
                  send       = 1'b1;
                  send_code  = cnm_pkg::NC_MM;
                  sa         = cfg_stay_active;
                  cy         = cfg_tx_cycle;
                  st.status  = cnm_pkg::IND_ON;
                  st.fsm     = cnm_pkg::ST_NET_ON;
                  st.rx_events[cnm_pkg::EV_SILENT2STARTUP] = 1'b0;
               end else if (cmd_on) begin
                  st.al_flag = 1'b1;
                  send       = 1'b1;
                  send_code  = cnm_pkg::NC_WU;
                  sa         = cfg_stay_active;
                  st.status  = cnm_pkg::IND_STARTUP;
                  st.fsm     = cnm_pkg::ST_STARTUP;
                  st.rx_events[cnm_pkg::EV_SILENT2STARTUP] = 1'b0;
               end else if (st.rx_events[cnm_pkg::EV_SILENT2STARTUP]) begin
                  st.rx_events[cnm_pkg::EV_SILENT2STARTUP] = 1'b0;
                  sa        = cfg_stay_active;
                  st.status = cnm_pkg::IND_STARTUP;
                  st.fsm    = cnm_pkg::ST_STARTUP;
               end else if (sl == TIMER_ZERO) begin
                  st.wakeup_latch = 1'b0;
                  sleep_req = 1'b1;
                  if (item.sleep_granted) begin
                     st.status = cnm_pkg::IND_OFF;
                     st.fsm    = cnm_pkg::ST_NET_OFF;
                     st.rx_events[cnm_pkg::EV_SILENT2STARTUP] = 1'b0;
                  end
               end
            end
            cnm_pkg::ST_NET_ON: begin
               sa = dec_sat(sa);
               if (!item.ignition_on) begin
                  if (!cmd_on)
                     st.al_flag = 1'b0;
                  if ((!cmd_on && sa == TIMER_ZERO) ||
                      st.rx_events[cnm_pkg::EV_ON2SILENT]) begin
                     st.on_code = cnm_pkg::NC_SA;
                     sl         = cfg_sleep_two;
                     st.status  = cnm_pkg::IND_SDN;
                     st.fsm     = cnm_pkg::ST_SILENT;
                  end else if (cmd_on && sa == TIMER_ZERO) begin
                     st.al_flag = item.local_active;
                     st.on_code = cnm_pkg::NC_SA;
                     sa         = cfg_stay_active;
                     st.status  = cnm_pkg::IND_ON;
                  end
               end else if (cmd_on && sa == TIMER_ZERO) begin
                  st.al_flag = item.local_active;
                  st.on_code = cnm_pkg::NC_MM;
                  sa         = cfg_stay_active;
                  st.status  = cnm_pkg::IND_ON;
               end
               st.rx_events[cnm_pkg::EV_ON2SILENT] = 1'b0;
               // The cycle timer wraps: a zero period gives all ones here.
               cy = cy - TIMER_ONE;
               if (cy == TIMER_ZERO) begin
                  cy        = cfg_tx_cycle;
                  send      = 1'b1;
                  send_code = st.on_code;
               end
            end
            default: begin
               st.fsm = cnm_pkg::ST_POWER_OFF;
            end
         endcase

         // Application transmission opens after a short delay in net on.
         if (st.fsm == cnm_pkg::ST_NET_ON && item.supply_ok) begin
            if (dc < DELAY_LAST)
               dc = dc + DELAY_WIDTH'(1);
            else
               st.app_tx_held = 1'b1;
         end else begin
            dc = '0;
            st.app_tx_held = 1'b0;
         end
      end

      // A frame is sent with the final AL flag; the master counter goes out once.
      if (send && cfg_tx_enable) begin
         status_byte = {st.al_flag, item.comm_fault, 6'd0};
         if (st.master_seen) begin
            status_byte    = status_byte | {2'b00, st.master_count};
            st.master_seen = 1'b0;
         end
         result.frame_valid  = 1'b1;
         result.frame_code   = send_code;
         result.frame_status = status_byte;
      end

      result.net_status    = st.status;
      result.app_tx_enable = st.app_tx_held;
      result.sleep_request = sleep_req;

      state_in        = st;
      sa_timer_in     = sa;
      cycle_timer_in  = cy;
      check_timer_in  = ck;
      silent_timer_in = sl;
      delay_cnt_in    = dc;
   end

endmodule

// File: src/can_network_mgmt_slave_fsm_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Carries
// req_ch    in         tick or received master frame transaction
// rsp_ch    out        optional NM frame, net status, tx enable, sleep request
// csr_*     in         configuration writes, indexes 0 to 4
//
// Each transaction is held in the input register and then processed into
// the result register, so one transaction is taken per cycle while the
// result is not stalled. The state update and the compare-and-decrement
// timers sit between those two registers. A stalled result holds the
// processing step; the input register still takes one more transaction meanwhile.
// Reset is synchronous and returns the state and the registers to defaults.

module can_network_mgmt_slave_fsm_unit #(
   parameter int TIMER_WIDTH = 16,
   parameter int TX_DELAY_TICKS = 1
) (
   input  logic                                clock,
   input  logic                                reset,
   cnm_req_if.sink                             req_ch,
   cnm_rsp_if.source                           rsp_ch,
   input  logic                                csr_we,
   input  logic [cnm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [cnm_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int DELAY_WIDTH = (TX_DELAY_TICKS > 0) ? $clog2(TX_DELAY_TICKS + 1) : 1;

   logic [TIMER_WIDTH-1:0] cfg_stay_active;
   logic [TIMER_WIDTH-1:0] cfg_tx_cycle;
   logic [TIMER_WIDTH-1:0] cfg_sleep_one;
   logic [TIMER_WIDTH-1:0] cfg_sleep_two;
   logic                   cfg_tx_enable;

   cnm_pkg::req_item_type  req_item;
   cnm_pkg::req_item_type  in_ff;
   logic                   in_valid_ff;
   logic                   in_valid_in;
   cnm_pkg::rsp_item_type  rsp_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   cnm_pkg::rsp_item_type  step_result;
   logic                   advance;
   logic                   req_take;

   cnm_pkg::ctl_state_type state_ff;
   cnm_pkg::ctl_state_type state_in;
   logic [TIMER_WIDTH-1:0] sa_timer_ff;
   logic [TIMER_WIDTH-1:0] sa_timer_in;
   logic [TIMER_WIDTH-1:0] cycle_timer_ff;
   logic [TIMER_WIDTH-1:0] cycle_timer_in;
   logic [TIMER_WIDTH-1:0] check_timer_ff;
   logic [TIMER_WIDTH-1:0] check_timer_in;
   logic [TIMER_WIDTH-1:0] silent_timer_ff;
   logic [TIMER_WIDTH-1:0] silent_timer_in;
   logic [DELAY_WIDTH-1:0] delay_cnt_ff;
   logic [DELAY_WIDTH-1:0] delay_cnt_in;

   cnm_csr #(
      .TIMER_WIDTH(TIMER_WIDTH)
   ) u_csr (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .stay_active_ticks (cfg_stay_active),
      .tx_cycle_ticks    (cfg_tx_cycle),
      .sleep_one_ticks   (cfg_sleep_one),
      .sleep_two_ticks   (cfg_sleep_two),
      .tx_enable         (cfg_tx_enable)
   );

   cnm_step #(
      .TIMER_WIDTH    (TIMER_WIDTH),
      .DELAY_WIDTH    (DELAY_WIDTH),
      .TX_DELAY_TICKS (TX_DELAY_TICKS)
   ) u_step (
      .item            (in_ff),
      .state_ff        (state_ff),
      .sa_timer_ff     (sa_timer_ff),
      .cycle_timer_ff  (cycle_timer_ff),
      .check_timer_ff  (check_timer_ff),
      .silent_timer_ff (silent_timer_ff),
      .delay_cnt_ff    (delay_cnt_ff),
      .cfg_stay_active (cfg_stay_active),
      .cfg_tx_cycle    (cfg_tx_cycle),
      .cfg_sleep_one   (cfg_sleep_one),
      .cfg_sleep_two   (cfg_sleep_two),
      .cfg_tx_enable   (cfg_tx_enable),
      .state_in        (state_in),
      .sa_timer_in     (sa_timer_in),
      .cycle_timer_in  (cycle_timer_in),
      .check_timer_in  (check_timer_in),
      .silent_timer_in (silent_timer_in),
      .delay_cnt_in    (delay_cnt_in),
      .result          (step_result)
   );

   assign req_item.mode          = req_ch.mode;
   assign req_item.ignition_on   = req_ch.ignition_on;
   assign req_item.sleep_allowed = req_ch.sleep_allowed;
   assign req_item.local_active  = req_ch.local_active;
   assign req_item.wakeup_event  = req_ch.wakeup_event;
   assign req_item.sleep_granted = req_ch.sleep_granted;
   assign req_item.comm_fault    = req_ch.comm_fault;
   assign req_item.supply_ok     = req_ch.supply_ok;
   assign req_item.rx_code       = req_ch.rx_code;
   assign req_item.rx_counter    = req_ch.rx_counter;

   // The held transaction is processed once the result register is free.
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take)
         in_ff <= req_item;
      if (advance)
         rsp_ff <= step_result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.fsm           <= cnm_pkg::ST_POWER_OFF;
         state_ff.al_flag       <= 1'b0;
         state_ff.on_code       <= cnm_pkg::NC_MM;
         state_ff.master_count  <= 6'd0;
         state_ff.master_seen   <= 1'b0;
         state_ff.rx_events     <= 4'd0;
         state_ff.wakeup_latch  <= 1'b0;
         state_ff.last_ignition <= 1'b0;
         state_ff.status        <= cnm_pkg::IND_OFF;
         state_ff.app_tx_held   <= 1'b0;
         sa_timer_ff            <= '0;
         cycle_timer_ff         <= '0;
         check_timer_ff         <= '0;
         silent_timer_ff        <= '0;
         delay_cnt_ff           <= '0;
      end else if (advance) begin
         state_ff        <= state_in;
         sa_timer_ff     <= sa_timer_in;
         cycle_timer_ff  <= cycle_timer_in;
         check_timer_ff  <= check_timer_in;
         silent_timer_ff <= silent_timer_in;
         delay_cnt_ff    <= delay_cnt_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.frame_valid   = rsp_ff.frame_valid;
   assign rsp_ch.frame_code    = rsp_ff.frame_code;
   assign rsp_ch.frame_status  = rsp_ff.frame_status;
   assign rsp_ch.net_status    = rsp_ff.net_status;
   assign rsp_ch.app_tx_enable = rsp_ff.app_tx_enable;
   assign rsp_ch.sleep_request = rsp_ff.sleep_request;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int TX_DELAY     = 1;
   localparam int LIMIT_CYCLES = 400000;
   localparam int LONG_HOLD    = 60;

   typedef enum logic [0:0] {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type                        kind;
      cnm_pkg::req_item_type               req;
      logic [cnm_pkg::CSR_INDEX_WIDTH-1:0] csr_idx;
      logic [cnm_pkg::CSR_DATA_WIDTH-1:0]  csr_val;
      bit                                  typed;
      cnm_pkg::rsp_item_type               rsp;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                                csr_we    = 1'b0;
   logic [cnm_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [cnm_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   cnm_req_if req_if ();
   cnm_rsp_if rsp_if ();

   can_network_mgmt_slave_fsm_unit #(
      .TIMER_WIDTH(16),
      .TX_DELAY_TICKS(TX_DELAY)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state and its copy of the configuration
   logic [2:0]  nm_state;
   logic [15:0] stay_tmr, cycle_tmr, check_tmr, silent_tmr;
   logic        al_bit;
   logic [1:0]  on_cmd;
   logic [5:0]  master_ctr;
   logic        ctr_pending;
   logic [3:0]  rx_ev;
   logic        wake_pending;
   logic        ign_prev;
   logic [2:0]  ind_reg;
   int          txen_delay;
   logic        app_tx;
   logic [15:0] cfg_stay, cfg_cycle, cfg_check, cfg_silent;
   logic        cfg_frames_on;
   cnm_pkg::rsp_item_type frame_out;

   cnm_pkg::rsp_item_type pending_nm_results[$];
   int                    mismatch_count = 0;
   int                    cycle_count = 0;
   bit                    gaps_on = 1'b1;
   bit                    rsp_hold_req = 1'b0;
   cnm_pkg::rsp_item_type seen_rsp, want_rsp;

   function automatic void nm_send(input logic [1:0] code, input logic fault);
      if (!cfg_frames_on)
         return;
      frame_out.frame_valid  = 1'b1;
      frame_out.frame_code   = code;
      frame_out.frame_status = {al_bit, fault, 6'd0};
      // The master counter goes out once, with the first frame actually sent.
      if (ctr_pending) begin
         frame_out.frame_status[5:0] = master_ctr;
         ctr_pending = 1'b0;
      end
   endfunction

   function automatic void nm_net_on_mm(input logic fault);
      on_cmd = cnm_pkg::NC_MM;
      nm_send(cnm_pkg::NC_MM, fault);
      stay_tmr  = cfg_stay;
      cycle_tmr = cfg_cycle;
      ind_reg   = cnm_pkg::IND_ON;
      nm_state  = cnm_pkg::ST_NET_ON;
   endfunction

   function automatic void nm_config(input logic [cnm_pkg::CSR_INDEX_WIDTH-1:0] idx,
                                     input logic [cnm_pkg::CSR_DATA_WIDTH-1:0] val);
      unique case (idx)
         cnm_pkg::CSR_STAY_ACTIVE: cfg_stay = val;
         cnm_pkg::CSR_TX_CYCLE:    cfg_cycle = val;
         cnm_pkg::CSR_SLEEP_ONE:   cfg_check = val;
         cnm_pkg::CSR_SLEEP_TWO:   cfg_silent = val;
         cnm_pkg::CSR_TX_ENABLE:   cfg_frames_on = val[0];
         default: ;
      endcase
   endfunction

   function automatic cnm_pkg::rsp_item_type nm_slave_predict(input cnm_pkg::req_item_type txn);
      logic cmd_on;
      logic fault;
      logic sleep_req;
      frame_out = '0;
      sleep_req = 1'b0;
      cmd_on = !txn.sleep_allowed;
      fault  = txn.comm_fault;
      if (txn.mode) begin
         master_ctr = txn.rx_counter;
         if (nm_state == cnm_pkg::ST_STARTUP && txn.rx_code == cnm_pkg::NC_SA)
            rx_ev[cnm_pkg::EV_STARTUP2ON] = 1'b1;
         if (nm_state == cnm_pkg::ST_CHECK && txn.rx_code == cnm_pkg::NC_SA)
            rx_ev[cnm_pkg::EV_CHECK2ON] = 1'b1;
         if (nm_state == cnm_pkg::ST_NET_OFF && wake_pending &&
             txn.rx_code == cnm_pkg::NC_SA)
            rx_ev[cnm_pkg::EV_CHECK2ON] = 1'b1;
         if (nm_state == cnm_pkg::ST_SILENT && txn.rx_code == cnm_pkg::NC_WU)
            rx_ev[cnm_pkg::EV_SILENT2STARTUP] = 1'b1;
         if (nm_state == cnm_pkg::ST_NET_ON) begin
            if (txn.rx_code == cnm_pkg::NC_S && !ign_prev)
               rx_ev[cnm_pkg::EV_ON2SILENT] = 1'b1;
            if ((txn.rx_code == cnm_pkg::NC_SA && !ign_prev) ||
                (txn.rx_code == cnm_pkg::NC_MM && ign_prev)) begin
               on_cmd      = txn.rx_code;
               stay_tmr    = cfg_stay;
               ind_reg     = cnm_pkg::IND_ON;
               cycle_tmr   = 16'd1;
               ctr_pending = 1'b1;
            end
         end
      end else begin
         ign_prev = txn.ignition_on;
         if (txn.wakeup_event)
            wake_pending = 1'b1;
         unique case (nm_state)
            cnm_pkg::ST_POWER_OFF, cnm_pkg::ST_NET_OFF: begin
               if (nm_state == cnm_pkg::ST_POWER_OFF) begin
                  ind_reg  = cnm_pkg::IND_OFF;
                  nm_state = cnm_pkg::ST_NET_OFF;
               end
               al_bit = txn.local_active;
               if (txn.ignition_on) begin
                  wake_pending = 1'b0;
                  nm_net_on_mm(fault);
                  rx_ev[cnm_pkg::EV_CHECK2ON] = 1'b0;
               end else if (cmd_on) begin
                  wake_pending = 1'b0;
                  stay_tmr = cfg_stay;
                  nm_send(cnm_pkg::NC_WU, fault);
                  ind_reg  = cnm_pkg::IND_STARTUP;
                  nm_state = cnm_pkg::ST_STARTUP;
                  rx_ev[cnm_pkg::EV_CHECK2ON] = 1'b0;
               end else if (wake_pending) begin
                  wake_pending = 1'b0;
                  check_tmr = cfg_check;
                  ind_reg   = cnm_pkg::IND_CHECK;
                  nm_state  = cnm_pkg::ST_CHECK;
               end
            end
            cnm_pkg::ST_STARTUP: begin
               if (txn.ignition_on) begin
                  nm_net_on_mm(fault);
                  rx_ev[cnm_pkg::EV_STARTUP2ON] = 1'b0;
               end else begin
                  al_bit = txn.local_active;
                  if (stay_tmr != 16'd0)
                     stay_tmr = stay_tmr - 16'd1;
                  if (stay_tmr == 16'd0 || rx_ev[cnm_pkg::EV_STARTUP2ON]) begin
                     rx_ev[cnm_pkg::EV_STARTUP2ON] = 1'b0;
                     nm_send(cnm_pkg::NC_SA, fault);
                     stay_tmr  = cfg_stay;
                     cycle_tmr = cfg_cycle;
                     ind_reg   = cnm_pkg::IND_ON;
                     nm_state  = cnm_pkg::ST_NET_ON;
                  end
               end
            end
            cnm_pkg::ST_CHECK: begin
               if (check_tmr != 16'd0)
                  check_tmr = check_tmr - 16'd1;
               if (txn.ignition_on) begin
                  nm_net_on_mm(fault);
                  rx_ev[cnm_pkg::EV_CHECK2ON] = 1'b0;
               end else if (rx_ev[cnm_pkg::EV_CHECK2ON]) begin
                  rx_ev[cnm_pkg::EV_CHECK2ON] = 1'b0;
                  nm_send(cnm_pkg::NC_SA, fault);
                  stay_tmr  = cfg_stay;
                  cycle_tmr = cfg_cycle;
                  ind_reg   = cnm_pkg::IND_ON;
                  nm_state  = cnm_pkg::ST_NET_ON;
               end else if (cmd_on) begin
                  al_bit = 1'b1;
                  nm_send(cnm_pkg::NC_WU, fault);
                  stay_tmr = cfg_stay;
                  ind_reg  = cnm_pkg::IND_STARTUP;
                  nm_state = cnm_pkg::ST_STARTUP;
                  rx_ev[cnm_pkg::EV_CHECK2ON] = 1'b0;
               end else if (check_tmr == 16'd0) begin
                  wake_pending = 1'b0;
                  sleep_req = 1'b1;
                  if (txn.sleep_granted) begin
                     ind_reg  = cnm_pkg::IND_OFF;
                     nm_state = cnm_pkg::ST_NET_OFF;
                     rx_ev[cnm_pkg::EV_CHECK2ON] = 1'b0;
                  end
               end
            end
            cnm_pkg::ST_SILENT: begin
               if (silent_tmr != 16'd0)
                  silent_tmr = silent_tmr - 16'd1;
               if (txn.ignition_on) begin
                  nm_net_on_mm(fault);
                  rx_ev[cnm_pkg::EV_SILENT2STARTUP] = 1'b0;
               end else if (cmd_on) begin
                  al_bit = 1'b1;
                  nm_send(cnm_pkg::NC_WU, fault);
                  stay_tmr = cfg_stay;
                  ind_reg  = cnm_pkg::IND_STARTUP;
                  nm_state = cnm_pkg::ST_STARTUP;
                  rx_ev[cnm_pkg::EV_SILENT2STARTUP] = 1'b0;
               end else if (rx_ev[cnm_pkg::EV_SILENT2STARTUP]) begin
                  rx_ev[cnm_pkg::EV_SILENT2STARTUP] = 1'b0;
                  stay_tmr = cfg_stay;
                  ind_reg  = cnm_pkg::IND_STARTUP;
                  nm_state = cnm_pkg::ST_STARTUP;
               end else if (silent_tmr == 16'd0) begin
                  wake_pending = 1'b0;
                  sleep_req = 1'b1;
                  if (txn.sleep_granted) begin
                     ind_reg  = cnm_pkg::IND_OFF;
                     nm_state = cnm_pkg::ST_NET_OFF;
                     rx_ev[cnm_pkg::EV_SILENT2STARTUP] = 1'b0;
                  end
               end
            end
            cnm_pkg::ST_NET_ON: begin
               if (stay_tmr != 16'd0)
                  stay_tmr = stay_tmr - 16'd1;
               if (!txn.ignition_on) begin
                  if (!cmd_on)
                     al_bit = 1'b0;
                  if ((!cmd_on && stay_tmr == 16'd0) || rx_ev[cnm_pkg::EV_ON2SILENT]) begin
                     on_cmd = cnm_pkg::NC_SA;
                     rx_ev[cnm_pkg::EV_ON2SILENT] = 1'b0;
                     silent_tmr = cfg_silent;
                     ind_reg    = cnm_pkg::IND_SDN;
                     nm_state   = cnm_pkg::ST_SILENT;
                  end else if (cmd_on && stay_tmr == 16'd0) begin
                     al_bit   = txn.local_active;
                     on_cmd   = cnm_pkg::NC_SA;
                     stay_tmr = cfg_stay;
                     ind_reg  = cnm_pkg::IND_ON;
                  end
               end else if (cmd_on && stay_tmr == 16'd0) begin
                  al_bit   = txn.local_active;
                  on_cmd   = cnm_pkg::NC_MM;
                  stay_tmr = cfg_stay;
                  ind_reg  = cnm_pkg::IND_ON;
               end
               rx_ev[cnm_pkg::EV_ON2SILENT] = 1'b0;
               // The cycle timer always counts, so a zero reload wraps to all ones.
               cycle_tmr = cycle_tmr - 16'd1;
               if (cycle_tmr == 16'd0) begin
                  cycle_tmr = cfg_cycle;
                  nm_send(on_cmd, fault);
               end
            end
            default: nm_state = cnm_pkg::ST_POWER_OFF;
         endcase
         if (nm_state == cnm_pkg::ST_NET_ON && txn.supply_ok) begin
            if (txen_delay < TX_DELAY)
               txen_delay++;
            else
               app_tx = 1'b1;
         end else begin
            txen_delay = 0;
            app_tx = 1'b0;
         end
      end
      frame_out.net_status    = ind_reg;
      frame_out.app_tx_enable = app_tx;
      frame_out.sleep_request = sleep_req;
      return frame_out;
   endfunction

   function automatic cnm_pkg::req_item_type tick_item(input logic ign, input logic sleep_ok,
                                                       input logic loc, input logic wake,
                                                       input logic grant, input logic fault,
                                                       input logic supply);
      cnm_pkg::req_item_type r;
      r = '0;
      r.ignition_on   = ign;
      r.sleep_allowed = sleep_ok;
      r.local_active  = loc;
      r.wakeup_event  = wake;
      r.sleep_granted = grant;
      r.comm_fault    = fault;
      r.supply_ok     = supply;
      return r;
   endfunction

   function automatic cnm_pkg::req_item_type frame_item(input logic [1:0] code,
                                                        input logic [5:0] counter);
      cnm_pkg::req_item_type r;
      r = '0;
      r.mode       = 1'b1;
      r.rx_code    = code;
      r.rx_counter = counter;
      return r;
   endfunction

   function automatic dir_row_type item_row(input cnm_pkg::req_item_type req);
      dir_row_type row;
      row = '0;
      row.kind = ROW_ITEM;
      row.req  = req;
      return row;
   endfunction

   function automatic dir_row_type typed_row(input cnm_pkg::req_item_type req,
                                             input cnm_pkg::rsp_item_type rsp);
      dir_row_type row;
      row = item_row(req);
      row.typed = 1'b1;
      row.rsp   = rsp;
      return row;
   endfunction

   function automatic dir_row_type csr_row(input logic [cnm_pkg::CSR_INDEX_WIDTH-1:0] idx,
                                           input logic [cnm_pkg::CSR_DATA_WIDTH-1:0] val);
      dir_row_type row;
      row = '0;
      row.kind    = ROW_CSR;
      row.csr_idx = idx;
      row.csr_val = val;
      return row;
   endfunction

   task automatic offer_item(input cnm_pkg::req_item_type txn, input bit use_typed,
                             input cnm_pkg::rsp_item_type typed_rsp);
      cnm_pkg::rsp_item_type predicted;
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_if.valid         = 1'b1;
      req_if.mode          = txn.mode;
      req_if.ignition_on   = txn.ignition_on;
      req_if.sleep_allowed = txn.sleep_allowed;
      req_if.local_active  = txn.local_active;
      req_if.wakeup_event  = txn.wakeup_event;
      req_if.sleep_granted = txn.sleep_granted;
      req_if.comm_fault    = txn.comm_fault;
      req_if.supply_ok     = txn.supply_ok;
      req_if.rx_code       = txn.rx_code;
      req_if.rx_counter    = txn.rx_counter;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predicted = nm_slave_predict(txn);
      pending_nm_results.push_back(use_typed ? typed_rsp : predicted);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending_nm_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [cnm_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [cnm_pkg::CSR_DATA_WIDTH-1:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      nm_config(idx, val);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   initial begin : rsp_sink
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            // Long back-pressure so the block fills up and stalls its input.
            rsp_hold_req = 1'b0;
            rsp_if.ready = 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            rsp_if.ready = 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge clock);
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         seen_rsp.frame_valid   = rsp_if.frame_valid;
         seen_rsp.frame_code    = rsp_if.frame_code;
         seen_rsp.frame_status  = rsp_if.frame_status;
         seen_rsp.net_status    = rsp_if.net_status;
         seen_rsp.app_tx_enable = rsp_if.app_tx_enable;
         seen_rsp.sleep_request = rsp_if.sleep_request;
         if (pending_nm_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected transaction fv=%0b code=%0d st=%02h net=%0d tx=%0b slp=%0b",
                        $time, seen_rsp.frame_valid, seen_rsp.frame_code, seen_rsp.frame_status,
                        seen_rsp.net_status, seen_rsp.app_tx_enable, seen_rsp.sleep_request);
         end else begin
            want_rsp = pending_nm_results.pop_front();
            if (seen_rsp.frame_valid !== want_rsp.frame_valid ||
                seen_rsp.frame_code !== want_rsp.frame_code ||
                seen_rsp.frame_status !== want_rsp.frame_status ||
                seen_rsp.net_status !== want_rsp.net_status ||
                seen_rsp.app_tx_enable !== want_rsp.app_tx_enable ||
                seen_rsp.sleep_request !== want_rsp.sleep_request) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: mismatch exp %0b/%0d/%02h/%0d/%0b/%0b got %0b/%0d/%02h/%0d/%0b/%0b",
                           $time, want_rsp.frame_valid, want_rsp.frame_code,
                           want_rsp.frame_status, want_rsp.net_status,
                           want_rsp.app_tx_enable, want_rsp.sleep_request,
                           seen_rsp.frame_valid, seen_rsp.frame_code, seen_rsp.frame_status,
                           seen_rsp.net_status, seen_rsp.app_tx_enable,
                           seen_rsp.sleep_request);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin : stimulus
      dir_row_type           dir_rows[$];
      cnm_pkg::req_item_type txn;
      int                    n_left;
      int                    run_len;
      logic                  ign_lvl, sleep_lvl;
      logic [15:0]           v_stay, v_cycle, v_check, v_silent;
      logic                  v_en;
      logic [14:0]           pad;

      req_if.valid = 1'b0;
      req_if.mode = 1'b0;
      req_if.ignition_on = 1'b0;
      req_if.sleep_allowed = 1'b0;
      req_if.local_active = 1'b0;
      req_if.wakeup_event = 1'b0;
      req_if.sleep_granted = 1'b0;
      req_if.comm_fault = 1'b0;
      req_if.supply_ok = 1'b0;
      req_if.rx_code = '0;
      req_if.rx_counter = '0;

      nm_state = cnm_pkg::ST_POWER_OFF;
      stay_tmr = '0;
      cycle_tmr = '0;
      check_tmr = '0;
      silent_tmr = '0;
      al_bit = 1'b0;
      on_cmd = cnm_pkg::NC_MM;
      master_ctr = '0;
      ctr_pending = 1'b0;
      rx_ev = '0;
      wake_pending = 1'b0;
      ign_prev = 1'b0;
      ind_reg = cnm_pkg::IND_OFF;
      txen_delay = 0;
      app_tx = 1'b0;
      cfg_stay = cnm_pkg::STAY_ACTIVE_RESET;
      cfg_cycle = cnm_pkg::TX_CYCLE_RESET;
      cfg_check = cnm_pkg::SLEEP_ONE_RESET;
      cfg_silent = cnm_pkg::SLEEP_TWO_RESET;
      cfg_frames_on = 1'b1;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Straight out of reset, with the default register values.
      dir_rows.push_back(typed_row(frame_item(cnm_pkg::NC_MM, 6'd63),
                                   '{1'b0, '0, 8'h00, cnm_pkg::IND_OFF, 1'b0, 1'b0}));
      dir_rows.push_back(typed_row(tick_item(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1),
                                   '{1'b1, cnm_pkg::NC_MM, 8'hC0, cnm_pkg::IND_ON, 1'b0, 1'b0}));
      dir_rows.push_back(typed_row(tick_item(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1),
                                   '{1'b0, '0, 8'h00, cnm_pkg::IND_ON, 1'b1, 1'b0}));
      dir_rows.push_back(typed_row(frame_item(cnm_pkg::NC_MM, 6'd42),
                                   '{1'b0, '0, 8'h00, cnm_pkg::IND_ON, 1'b1, 1'b0}));
      dir_rows.push_back(typed_row(tick_item(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1),
                                   '{1'b1, cnm_pkg::NC_MM, 8'hAA, cnm_pkg::IND_ON, 1'b1, 1'b0}));
      dir_rows.push_back(csr_row(cnm_pkg::CSR_STAY_ACTIVE, 16'd2));
      dir_rows.push_back(csr_row(cnm_pkg::CSR_TX_CYCLE, 16'd3));
      dir_rows.push_back(csr_row(cnm_pkg::CSR_SLEEP_ONE, 16'd2));
      dir_rows.push_back(csr_row(cnm_pkg::CSR_SLEEP_TWO, 16'd2));
      dir_rows.push_back(csr_row(cnm_pkg::CSR_TX_ENABLE, 16'd1));
      // Master silent command leads to shutdown; the sleep request repeats until granted.
      dir_rows.push_back(item_row(tick_item(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1)));
      dir_rows.push_back(item_row(frame_item(cnm_pkg::NC_S, 6'd5)));
      repeat (4)
         dir_rows.push_back(item_row(tick_item(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1)));
      dir_rows.push_back(item_row(tick_item(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1)));
      // Bus wakeup goes to wait-check, a stay-active master frame brings the net on.
      dir_rows.push_back(item_row(tick_item(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1)));
      dir_rows.push_back(item_row(frame_item(cnm_pkg::NC_SA, 6'd7)));
      dir_rows.push_back(item_row(tick_item(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1)));
      // Frames suppressed: the counter must be held for the next frame sent.
      dir_rows.push_back(csr_row(cnm_pkg::CSR_TX_ENABLE, 16'd0));
      dir_rows.push_back(item_row(frame_item(cnm_pkg::NC_SA, 6'd9)));
      dir_rows.push_back(item_row(tick_item(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1)));
      dir_rows.push_back(csr_row(cnm_pkg::CSR_TX_ENABLE, 16'hFFFF));
      dir_rows.push_back(csr_row(cnm_pkg::CSR_TX_CYCLE, 16'd0));
      dir_rows.push_back(csr_row(cnm_pkg::CSR_STAY_ACTIVE, 16'd0));
      repeat (4)
         dir_rows.push_back(item_row(tick_item(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1)));
      dir_rows.push_back(csr_row(cnm_pkg::CSR_STAY_ACTIVE, 16'hFFFF));
      dir_rows.push_back(csr_row(cnm_pkg::CSR_TX_CYCLE, 16'hFFFF));
      dir_rows.push_back(csr_row(cnm_pkg::CSR_SLEEP_ONE, 16'hFFFF));
      dir_rows.push_back(csr_row(cnm_pkg::CSR_SLEEP_TWO, 16'hFFFF));
      dir_rows.push_back(item_row(tick_item(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1)));
      dir_rows.push_back(item_row(frame_item(cnm_pkg::NC_WU, 6'd0)));
      dir_rows.push_back(item_row(tick_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)));

      foreach (dir_rows[r]) begin
         if (dir_rows[r].kind == ROW_CSR) begin
            drain_results();
            csr_write(dir_rows[r].csr_idx, dir_rows[r].csr_val);
         end else begin
            offer_item(dir_rows[r].req, dir_rows[r].typed, dir_rows[r].rsp);
         end
      end

      for (int phase = 0; phase < 10; phase++) begin
         drain_results();
         unique case (phase)
            0: begin
               v_stay = 16'd1; v_cycle = 16'd1; v_check = 16'd1; v_silent = 16'd1;
               v_en = 1'b1;
            end
            3: begin
               v_stay = 16'hFFFF; v_cycle = 16'hFFFF; v_check = 16'hFFFF;
               v_silent = 16'hFFFF; v_en = 1'b1;
            end
            5: begin
               v_stay = 16'd0; v_cycle = 16'd0; v_check = 16'd0; v_silent = 16'd0;
               v_en = 1'b1;
            end
            default: begin
               v_stay   = 16'($urandom_range(1, 12));
               v_cycle  = 16'($urandom_range(1, 12));
               v_check  = 16'($urandom_range(1, 12));
               v_silent = 16'($urandom_range(1, 12));
               v_en     = (phase != 7);
            end
         endcase
         pad = 15'($urandom);
         csr_write(cnm_pkg::CSR_STAY_ACTIVE, v_stay);
         csr_write(cnm_pkg::CSR_TX_CYCLE, v_cycle);
         csr_write(cnm_pkg::CSR_SLEEP_ONE, v_check);
         csr_write(cnm_pkg::CSR_SLEEP_TWO, v_silent);
         csr_write(cnm_pkg::CSR_TX_ENABLE, {pad, v_en});
         if (phase == 2)
            rsp_hold_req = 1'b1;
         if (phase == 9)
            gaps_on = 1'b0;

         // Ignition and sleep condition are held over short runs so that timers
         // can expire; master frames and the other flags vary freely.
         n_left = 95;
         while (n_left > 0) begin
            ign_lvl   = ($urandom_range(0, 3) == 0);
            sleep_lvl = ($urandom_range(0, 2) != 0);
            run_len   = $urandom_range(2, 16);
            while (run_len > 0 && n_left > 0) begin
               txn.mode          = ($urandom_range(0, 4) == 0);
               txn.ignition_on   = ($urandom_range(0, 15) == 0) ? !ign_lvl : ign_lvl;
               txn.sleep_allowed = ($urandom_range(0, 15) == 0) ? !sleep_lvl : sleep_lvl;
               txn.local_active  = 1'($urandom_range(0, 1));
               txn.wakeup_event  = ($urandom_range(0, 11) == 0);
               txn.sleep_granted = ($urandom_range(0, 2) != 0);
               txn.comm_fault    = 1'($urandom_range(0, 1));
               txn.supply_ok     = ($urandom_range(0, 5) != 0);
               txn.rx_code       = 2'($urandom_range(0, 3));
               txn.rx_counter    = 6'($urandom_range(0, 63));
               offer_item(txn, 1'b0, '0);
               run_len--;
               n_left--;
            end
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: sim.f
src/cnm_pkg.sv
src/cnm_ifs.sv
src/cnm_csr.sv
src/cnm_step.sv
src/can_network_mgmt_slave_fsm_unit.sv
sim/tb_top.sv
